>>> rtl/cjv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cjv_pkg;

  // Port widths
  localparam int DIR_W   = 16;
  localparam int DEV_W   = 24;
  localparam int ACC_W   = 32;
  localparam int SPEED_W = 32;
  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Internal datapath widths
  localparam int DOT_W  = 32;              // one signed Q1.15 x Q1.15 product
  localparam int COS_W  = 34;              // signed Q2.30 cosine with headroom
  localparam int AXP_W  = DIR_W + DEV_W;   // |u| * dev
  localparam int P_W    = 24;              // per-axis deviation term, Q.16
  localparam int SQR_W  = 2 * P_W;
  localparam int SUM_W  = SQR_W + 2;
  localparam int X_W    = 30;              // (1 - cos) / 2, Q.30
  localparam int NORM_W = 25;
  localparam int FRAC_W = 30;              // half-angle sine, Q.30
  localparam int NUM_W  = NORM_W + FRAC_W;
  localparam int DEN_W  = 31;
  localparam int QUO_W  = 36;
  localparam int DIV_EXT_W = DEN_W + QUO_W - 1;
  localparam int RAD_LO_W  = 32;
  localparam int RAD_HI_W  = QUO_W - RAD_LO_W;
  localparam int PROD_W    = QUO_W + ACC_W;

  // Square root unit: one root bit per stage
  localparam int SQ_RAD_W  = 64;
  localparam int SQ_ROOT_W = SQ_RAD_W / 2;
  localparam int SQ_REM_W  = SQ_ROOT_W + 2;
  localparam int SQ_STAGES = SQ_ROOT_W;

  // Edges from the first stage register to the output register
  localparam int PIPE_LAT = 3 + SQ_STAGES + 2 + QUO_W + 2 + SQ_STAGES + 1;

  localparam logic signed [COS_W-1:0] COS_LIMIT  = 34'sd1063004406;
  localparam logic signed [COS_W-1:0] ONE_COS    = 34'sd1073741824;
  localparam logic [SQ_ROOT_W-1:0]    ONE_Q30    = 32'd1073741824;
  localparam logic [SPEED_W-1:0]      STRAIGHT   = 32'd2560000000;
  localparam logic [PROD_W-1:0]       STRAIGHT_SQ = 68'd6553600000000000000;

  localparam logic [DEV_W-1:0] DEV_RESET = 24'd3277;
  localparam logic [ACC_W-1:0] ACC_RESET = 32'd100000;

  typedef enum logic [KIND_W-1:0] {
    KIND_COMPUTED = 2'd0,
    KIND_STRAIGHT = 2'd1,
    KIND_REVERSAL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_DEV_X = 2'd0,
    REG_DEV_Y = 2'd1,
    REG_DEV_Z = 2'd2,
    REG_ACCEL = 2'd3
  } reg_e;

  // Sideband that rides through the iterative units
  typedef struct packed {
    kind_e kind;
    logic  sat;
  } tag_t;

endpackage

`default_nettype wire

>>> rtl/corner_junction_velocity_limit_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Depth: 109 register stages, from the register that accepts the word to the output
//   register that drives the result strobe.
// Throughput: one word per cycle, sustained; busy is never raised and results
//   cannot be held off. Depth is set by two 32-stage square roots and a 36-stage divider.
// Reset: valid bits clear at once, config registers return to their defaults.

module corner_junction_velocity_limit_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic signed [cjv_pkg::DIR_W-1:0]  prev_dir_x_i,
  input  logic signed [cjv_pkg::DIR_W-1:0]  prev_dir_y_i,
  input  logic signed [cjv_pkg::DIR_W-1:0]  prev_dir_z_i,
  input  logic signed [cjv_pkg::DIR_W-1:0]  next_dir_x_i,
  input  logic signed [cjv_pkg::DIR_W-1:0]  next_dir_y_i,
  input  logic signed [cjv_pkg::DIR_W-1:0]  next_dir_z_i,
  // result strobe
  output logic                              result_valid_o,
  output logic [cjv_pkg::SPEED_W-1:0]       corner_speed_o,
  output logic [cjv_pkg::KIND_W-1:0]        corner_kind_o,
  // config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cjv_pkg::ADDR_W-1:0]        paddr,
  input  logic [cjv_pkg::DATA_W-1:0]        pwdata,
  output logic [cjv_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [cjv_pkg::DEV_W-1:0] dev_x_q, dev_y_q, dev_z_q;
  logic [cjv_pkg::ACC_W-1:0] accel_q;
  logic                      cfg_wr;
  cjv_pkg::reg_e             cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cjv_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_x_q <= cjv_pkg::DEV_RESET;
      dev_y_q <= cjv_pkg::DEV_RESET;
      dev_z_q <= cjv_pkg::DEV_RESET;
      accel_q <= cjv_pkg::ACC_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        cjv_pkg::REG_DEV_X: dev_x_q <= pwdata[cjv_pkg::DEV_W-1:0];
        cjv_pkg::REG_DEV_Y: dev_y_q <= pwdata[cjv_pkg::DEV_W-1:0];
        cjv_pkg::REG_DEV_Z: dev_z_q <= pwdata[cjv_pkg::DEV_W-1:0];
        cjv_pkg::REG_ACCEL: accel_q <= pwdata[cjv_pkg::ACC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      cjv_pkg::REG_DEV_X: prdata = {{(cjv_pkg::DATA_W - cjv_pkg::DEV_W){1'b0}}, dev_x_q};
      cjv_pkg::REG_DEV_Y: prdata = {{(cjv_pkg::DATA_W - cjv_pkg::DEV_W){1'b0}}, dev_y_q};
      cjv_pkg::REG_DEV_Z: prdata = {{(cjv_pkg::DATA_W - cjv_pkg::DEV_W){1'b0}}, dev_z_q};
      cjv_pkg::REG_ACCEL: prdata = accel_q;
      default:            prdata = '0;
    endcase
  end

  // No stalls anywhere: a word enters every cycle start is high.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // S1: dot-product terms and |u| * dev per axis
  // ---------------------------------------------------------------------------
  logic                              s1_vld_q;
  logic signed [cjv_pkg::DOT_W-1:0]  s1_dot_q [3];
  logic [cjv_pkg::AXP_W-1:0]         s1_pa_q  [3];
  logic [cjv_pkg::AXP_W-1:0]         s1_pb_q  [3];
  logic signed [cjv_pkg::DOT_W-1:0]  s1_dot_d [3];
  logic [cjv_pkg::AXP_W-1:0]         s1_pa_d  [3];
  logic [cjv_pkg::AXP_W-1:0]         s1_pb_d  [3];

  always_comb begin
    logic signed [cjv_pkg::DIR_W-1:0] a [3];
    logic signed [cjv_pkg::DIR_W-1:0] b [3];
    logic [cjv_pkg::DEV_W-1:0]        dev [3];
    logic [cjv_pkg::DIR_W-1:0]        mag_a, mag_b;
    a[0] = prev_dir_x_i;  a[1] = prev_dir_y_i;  a[2] = prev_dir_z_i;
    b[0] = next_dir_x_i;  b[1] = next_dir_y_i;  b[2] = next_dir_z_i;
    dev[0] = dev_x_q;     dev[1] = dev_y_q;     dev[2] = dev_z_q;
    for (int i = 0; i < 3; i++) begin
      // -32768 maps to 32768 as unsigned, which is what we want
      mag_a = a[i][cjv_pkg::DIR_W-1] ? (~a[i] + 1'b1) : a[i];
      mag_b = b[i][cjv_pkg::DIR_W-1] ? (~b[i] + 1'b1) : b[i];
      s1_dot_d[i] = cjv_pkg::DOT_W'(a[i]) * cjv_pkg::DOT_W'(b[i]);
      s1_pa_d[i]  = cjv_pkg::AXP_W'(mag_a) * cjv_pkg::AXP_W'(dev[i]);
      s1_pb_d[i]  = cjv_pkg::AXP_W'(mag_b) * cjv_pkg::AXP_W'(dev[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // S2: cosine sum, truncate deviation terms to Q.16
  // ---------------------------------------------------------------------------
  logic                              s2_vld_q;
  logic signed [cjv_pkg::COS_W-1:0]  s2_cos_q;
  logic [cjv_pkg::P_W-1:0]           s2_pa_q [3];
  logic [cjv_pkg::P_W-1:0]           s2_pb_q [3];
  logic signed [cjv_pkg::COS_W-1:0]  s2_cos_d;

  always_comb begin
    s2_cos_d = -(cjv_pkg::COS_W'(s1_dot_q[0]) + cjv_pkg::COS_W'(s1_dot_q[1])
                 + cjv_pkg::COS_W'(s1_dot_q[2]));
  end

  // ---------------------------------------------------------------------------
  // S3: squares, corner class, (1 - cos) / 2
  // ---------------------------------------------------------------------------
  logic                              s3_vld_q;
  logic [cjv_pkg::SQR_W-1:0]         s3_sa_q [3];
  logic [cjv_pkg::SQR_W-1:0]         s3_sb_q [3];
  cjv_pkg::kind_e                    s3_kind_q;
  logic [cjv_pkg::X_W-1:0]           s3_x_q;
  cjv_pkg::kind_e                    s3_kind_d;
  logic signed [cjv_pkg::COS_W-1:0]  s3_t;

  always_comb begin
    if (s2_cos_q < -cjv_pkg::COS_LIMIT) begin
      s3_kind_d = cjv_pkg::KIND_STRAIGHT;
    end else if (s2_cos_q > cjv_pkg::COS_LIMIT) begin
      s3_kind_d = cjv_pkg::KIND_REVERSAL;
    end else begin
      s3_kind_d = cjv_pkg::KIND_COMPUTED;
    end
  end

  assign s3_t = cjv_pkg::ONE_COS - s2_cos_q;

  // ---------------------------------------------------------------------------
  // S4: sums of squares; feeds the three root units
  // ---------------------------------------------------------------------------
  logic                        s4_vld_q;
  logic [cjv_pkg::SUM_W-1:0]   s4_suma_q, s4_sumb_q;
  logic [cjv_pkg::X_W-1:0]     s4_x_q;
  cjv_pkg::kind_e              s4_kind_q;
  cjv_pkg::tag_t               s4_tag;

  assign s4_tag.kind = s4_kind_q;
  assign s4_tag.sat  = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start && !busy;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s1_dot_q[i] <= s1_dot_d[i];
      s1_pa_q[i]  <= s1_pa_d[i];
      s1_pb_q[i]  <= s1_pb_d[i];
      s2_pa_q[i]  <= s1_pa_q[i][cjv_pkg::P_W+14:15];
      s2_pb_q[i]  <= s1_pb_q[i][cjv_pkg::P_W+14:15];
      s3_sa_q[i]  <= cjv_pkg::SQR_W'(s2_pa_q[i]) * cjv_pkg::SQR_W'(s2_pa_q[i]);
      s3_sb_q[i]  <= cjv_pkg::SQR_W'(s2_pb_q[i]) * cjv_pkg::SQR_W'(s2_pb_q[i]);
    end
    s2_cos_q  <= s2_cos_d;
    s3_kind_q <= s3_kind_d;
    s3_x_q    <= s3_t[cjv_pkg::X_W:1];
    s4_suma_q <= cjv_pkg::SUM_W'(s3_sa_q[0]) + cjv_pkg::SUM_W'(s3_sa_q[1])
                 + cjv_pkg::SUM_W'(s3_sa_q[2]);
    s4_sumb_q <= cjv_pkg::SUM_W'(s3_sb_q[0]) + cjv_pkg::SUM_W'(s3_sb_q[1])
                 + cjv_pkg::SUM_W'(s3_sb_q[2]);
    s4_x_q    <= s3_x_q;
    s4_kind_q <= s3_kind_q;
  end

  // ---------------------------------------------------------------------------
  // Root units: two fused deviation norms and the half-angle sine
  // ---------------------------------------------------------------------------
  logic [cjv_pkg::SQ_ROOT_W-1:0] norm_a, norm_b, sine;
  logic                          sine_vld;
  cjv_pkg::tag_t                 sine_tag;

  cjv_sqrt u_norm_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_vld_q),
    .rad_i   ({{(cjv_pkg::SQ_RAD_W - cjv_pkg::SUM_W){1'b0}}, s4_suma_q}),
    .tag_i   (s4_tag),
    .valid_o (),
    .root_o  (norm_a),
    .tag_o   ()
  );

  cjv_sqrt u_norm_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_vld_q),
    .rad_i   ({{(cjv_pkg::SQ_RAD_W - cjv_pkg::SUM_W){1'b0}}, s4_sumb_q}),
    .tag_i   (s4_tag),
    .valid_o (),
    .root_o  (norm_b),
    .tag_o   ()
  );

  // s = sqrt(x << 30), Q.30
  cjv_sqrt u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_vld_q),
    .rad_i   ({{(cjv_pkg::SQ_RAD_W - cjv_pkg::X_W - 30){1'b0}}, s4_x_q, 30'd0}),
    .tag_i   (s4_tag),
    .valid_o (sine_vld),
    .root_o  (sine),
    .tag_o   (sine_tag)
  );

  // ---------------------------------------------------------------------------
  // S5: average deviation, radius denominator
  // S6: numerator delta * s
  // ---------------------------------------------------------------------------
  logic                         s5_vld_q, s6_vld_q;
  logic [cjv_pkg::NORM_W-1:0]   s5_delta_q;
  logic [cjv_pkg::FRAC_W-1:0]   s5_s_q;
  logic [cjv_pkg::DEN_W-1:0]    s5_den_q, s6_den_q;
  cjv_pkg::tag_t                s5_tag_q, s6_tag_q;
  logic [cjv_pkg::NUM_W-1:0]    s6_num_q;
  logic [cjv_pkg::NORM_W:0]     norm_sum;
  logic [cjv_pkg::SQ_ROOT_W-1:0] one_minus_s;
  logic [cjv_pkg::DEN_W-1:0]    den_d;

  assign norm_sum    = {1'b0, norm_a[cjv_pkg::NORM_W-1:0]}
                     + {1'b0, norm_b[cjv_pkg::NORM_W-1:0]};
  assign one_minus_s = cjv_pkg::ONE_Q30 - sine;
  // s stays below one on every computed corner; the guard keeps the divisor nonzero
  assign den_d       = (sine < cjv_pkg::ONE_Q30) ? one_minus_s[cjv_pkg::DEN_W-1:0]
                                                 : cjv_pkg::DEN_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= sine_vld;
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_delta_q <= norm_sum[cjv_pkg::NORM_W:1];
    s5_s_q     <= sine[cjv_pkg::FRAC_W-1:0];
    s5_den_q   <= den_d;
    s5_tag_q   <= sine_tag;
    s6_num_q   <= cjv_pkg::NUM_W'(s5_delta_q) * cjv_pkg::NUM_W'(s5_s_q);
    s6_den_q   <= s5_den_q;
    s6_tag_q   <= s5_tag_q;
  end

  // ---------------------------------------------------------------------------
  // Radius = delta * s / (1 - s), Q.16
  // ---------------------------------------------------------------------------
  logic [cjv_pkg::QUO_W-1:0] radius;
  logic                      radius_vld;
  cjv_pkg::tag_t             radius_tag;

  cjv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s6_vld_q),
    .num_i   (s6_num_q),
    .den_i   (s6_den_q),
    .tag_i   (s6_tag_q),
    .valid_o (radius_vld),
    .quo_o   (radius),
    .tag_o   (radius_tag)
  );

  // ---------------------------------------------------------------------------
  // S7: radius * accel as two partial products
  // S8: combine, saturate against straight-line speed squared
  // ---------------------------------------------------------------------------
  logic                                        s7_vld_q, s8_vld_q;
  logic [cjv_pkg::RAD_LO_W+cjv_pkg::ACC_W-1:0] s7_plo_q;
  logic [cjv_pkg::RAD_HI_W+cjv_pkg::ACC_W-1:0] s7_phi_q;
  cjv_pkg::tag_t                               s7_tag_q, s8_tag_q;
  logic [cjv_pkg::SQ_RAD_W-1:0]                s8_rad_q;
  logic [cjv_pkg::PROD_W-1:0]                  prod;
  logic                                        prod_sat;
  cjv_pkg::tag_t                               s8_tag_d;

  assign prod = {s7_phi_q, {cjv_pkg::RAD_LO_W{1'b0}}}
              + {{cjv_pkg::RAD_HI_W{1'b0}}, s7_plo_q};
  assign prod_sat = prod > cjv_pkg::STRAIGHT_SQ;

  always_comb begin
    s8_tag_d     = s7_tag_q;
    s8_tag_d.sat = prod_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
      s8_vld_q <= 1'b0;
    end else begin
      s7_vld_q <= radius_vld;
      s8_vld_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_plo_q <= {{cjv_pkg::ACC_W{1'b0}}, radius[cjv_pkg::RAD_LO_W-1:0]}
              * {{cjv_pkg::RAD_LO_W{1'b0}}, accel_q};
    s7_phi_q <= {{cjv_pkg::ACC_W{1'b0}}, radius[cjv_pkg::QUO_W-1:cjv_pkg::RAD_LO_W]}
              * {{cjv_pkg::RAD_HI_W{1'b0}}, accel_q};
    s7_tag_q <= radius_tag;
    s8_rad_q <= prod_sat ? '0 : prod[cjv_pkg::SQ_RAD_W-1:0];
    s8_tag_q <= s8_tag_d;
  end

  // ---------------------------------------------------------------------------
  // Speed = sqrt(radius * accel), Q.8
  // ---------------------------------------------------------------------------
  logic [cjv_pkg::SQ_ROOT_W-1:0] speed_root;
  logic                          speed_vld;
  cjv_pkg::tag_t                 speed_tag;

  cjv_sqrt u_speed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s8_vld_q),
    .rad_i   (s8_rad_q),
    .tag_i   (s8_tag_q),
    .valid_o (speed_vld),
    .root_o  (speed_root),
    .tag_o   (speed_tag)
  );

  // ---------------------------------------------------------------------------
  // Output register: corner class or saturation overrides the computed speed
  // ---------------------------------------------------------------------------
  logic                          out_vld_q;
  logic [cjv_pkg::SPEED_W-1:0]   out_speed_q, out_speed_d;
  cjv_pkg::kind_e                out_kind_q;

  always_comb begin
    case (speed_tag.kind)
      cjv_pkg::KIND_STRAIGHT: out_speed_d = cjv_pkg::STRAIGHT;
      cjv_pkg::KIND_REVERSAL: out_speed_d = '0;
      default: out_speed_d = speed_tag.sat ? cjv_pkg::STRAIGHT : speed_root;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= speed_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    out_speed_q <= out_speed_d;
    out_kind_q  <= speed_tag.kind;
  end

  assign result_valid_o = out_vld_q;
  assign corner_speed_o = out_speed_q;
  assign corner_kind_o  = out_kind_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // every word that enters leaves after the full pipeline depth
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> ##(cjv_pkg::PIPE_LAT) result_valid_o)
    else $error("word lost in pipeline");

  // computed speeds never pass the straight-line limit
  a_speed_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> corner_speed_o <= cjv_pkg::STRAIGHT)
    else $error("speed above straight-line value");

  // a reversal always reports zero speed
  a_reversal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && corner_kind_o == cjv_pkg::KIND_REVERSAL |-> corner_speed_o == '0)
    else $error("reversal with nonzero speed");

endmodule

`default_nettype wire

>>> rtl/cjv_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root, floor, one root bit per stage.
module cjv_sqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [cjv_pkg::SQ_RAD_W-1:0]    rad_i,
  input  cjv_pkg::tag_t                   tag_i,
  output logic                            valid_o,
  output logic [cjv_pkg::SQ_ROOT_W-1:0]   root_o,
  output cjv_pkg::tag_t                   tag_o
);

  typedef struct packed {
    logic [cjv_pkg::SQ_REM_W-1:0]  rem;
    logic [cjv_pkg::SQ_ROOT_W-1:0] root;
    logic [cjv_pkg::SQ_RAD_W-1:0]  rad;
    cjv_pkg::tag_t                 tag;
  } sq_stage_t;

  sq_stage_t st_q [cjv_pkg::SQ_STAGES];
  sq_stage_t st_d [cjv_pkg::SQ_STAGES];
  logic [cjv_pkg::SQ_STAGES-1:0] vld_q;

  always_comb begin
    sq_stage_t src;
    logic [cjv_pkg::SQ_REM_W-1:0] rem_t;
    logic [cjv_pkg::SQ_REM_W-1:0] trial;
    for (int k = 0; k < cjv_pkg::SQ_STAGES; k++) begin
      if (k == 0) begin
        src.rem  = '0;
        src.root = '0;
        src.rad  = rad_i;
        src.tag  = tag_i;
      end else begin
        src = st_q[k-1];
      end
      // bring down the next two radicand bits
      rem_t = {src.rem[cjv_pkg::SQ_ROOT_W-1:0],
               src.rad[cjv_pkg::SQ_RAD_W-1 -: 2]};
      trial = {src.root, 2'b01};
      st_d[k].rad = {src.rad[cjv_pkg::SQ_RAD_W-3:0], 2'b00};
      st_d[k].tag = src.tag;
      if (rem_t >= trial) begin
        st_d[k].rem  = rem_t - trial;
        st_d[k].root = {src.root[cjv_pkg::SQ_ROOT_W-2:0], 1'b1};
      end else begin
        st_d[k].rem  = rem_t;
        st_d[k].root = {src.root[cjv_pkg::SQ_ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[cjv_pkg::SQ_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < cjv_pkg::SQ_STAGES; k++) begin
      st_q[k] <= st_d[k];
    end
  end

  assign valid_o = vld_q[cjv_pkg::SQ_STAGES-1];
  assign root_o  = st_q[cjv_pkg::SQ_STAGES-1].root;
  assign tag_o   = st_q[cjv_pkg::SQ_STAGES-1].tag;

endmodule

`default_nettype wire

>>> rtl/cjv_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, MSB first.
module cjv_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [cjv_pkg::NUM_W-1:0]    num_i,
  input  logic [cjv_pkg::DEN_W-1:0]    den_i,
  input  cjv_pkg::tag_t                tag_i,
  output logic                         valid_o,
  output logic [cjv_pkg::QUO_W-1:0]    quo_o,
  output cjv_pkg::tag_t                tag_o
);

  typedef struct packed {
    logic [cjv_pkg::NUM_W-1:0] rem;
    logic [cjv_pkg::DEN_W-1:0] den;
    logic [cjv_pkg::QUO_W-1:0] quo;
    cjv_pkg::tag_t             tag;
  } div_stage_t;

  div_stage_t st_q [cjv_pkg::QUO_W];
  div_stage_t st_d [cjv_pkg::QUO_W];
  logic [cjv_pkg::QUO_W-1:0] vld_q;

  always_comb begin
    div_stage_t src;
    logic [cjv_pkg::DIV_EXT_W-1:0] ext_rem;
    logic [cjv_pkg::DIV_EXT_W-1:0] trial;
    logic [cjv_pkg::DIV_EXT_W-1:0] diff;
    for (int k = 0; k < cjv_pkg::QUO_W; k++) begin
      if (k == 0) begin
        src.rem = num_i;
        src.den = den_i;
        src.quo = '0;
        src.tag = tag_i;
      end else begin
        src = st_q[k-1];
      end
      ext_rem = {{(cjv_pkg::DIV_EXT_W - cjv_pkg::NUM_W){1'b0}}, src.rem};
      trial   = {{(cjv_pkg::DIV_EXT_W - cjv_pkg::DEN_W){1'b0}}, src.den}
                << (cjv_pkg::QUO_W - 1 - k);
      diff    = ext_rem - trial;
      st_d[k].den = src.den;
      st_d[k].tag = src.tag;
      if (ext_rem >= trial) begin
        st_d[k].rem = diff[cjv_pkg::NUM_W-1:0];
        st_d[k].quo = {src.quo[cjv_pkg::QUO_W-2:0], 1'b1};
      end else begin
        st_d[k].rem = src.rem;
        st_d[k].quo = {src.quo[cjv_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[cjv_pkg::QUO_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < cjv_pkg::QUO_W; k++) begin
      st_q[k] <= st_d[k];
    end
  end

  assign valid_o = vld_q[cjv_pkg::QUO_W-1];
  assign quo_o   = st_q[cjv_pkg::QUO_W-1].quo;
  assign tag_o   = st_q[cjv_pkg::QUO_W-1].tag;

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int  LATENCY     = cjv_pkg::PIPE_LAT + 8;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  DIRECTED_N  = 20;
  localparam int  RANDOM_N    = 750;
  localparam logic [63:0] Q30_ONE  = 64'd1073741824;
  localparam logic [63:0] CORNER_SQ = 64'd6553600000000000000;

  // Expected corner speed and class for one junction
  typedef struct {
    logic [cjv_pkg::SPEED_W-1:0] speed;
    cjv_pkg::kind_e              kind;
  } corner_t;

  // Keeps its own copy of the registers and predicts each accepted word
  class corner_scoreboard;
    logic [cjv_pkg::DEV_W-1:0] dev_x, dev_y, dev_z;
    logic [cjv_pkg::ACC_W-1:0] accel;
    corner_t                   pending[$];
    int                        mismatches;

    function void reset_regs();
      dev_x = cjv_pkg::DEV_RESET;
      dev_y = cjv_pkg::DEV_RESET;
      dev_z = cjv_pkg::DEV_RESET;
      accel = cjv_pkg::ACC_RESET;
    endfunction

    function void write_reg(cjv_pkg::reg_e idx, logic [cjv_pkg::DATA_W-1:0] val);
      case (idx)
        cjv_pkg::REG_DEV_X: dev_x = val[cjv_pkg::DEV_W-1:0];
        cjv_pkg::REG_DEV_Y: dev_y = val[cjv_pkg::DEV_W-1:0];
        cjv_pkg::REG_DEV_Z: dev_z = val[cjv_pkg::DEV_W-1:0];
        cjv_pkg::REG_ACCEL: accel = val;
        default: ;
      endcase
    endfunction

    // Bit-serial integer square root, floor
    function logic [63:0] root(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [63:0] axis_sq(logic signed [cjv_pkg::DIR_W-1:0] u,
                                  logic [cjv_pkg::DEV_W-1:0] dev);
      logic [63:0] mag, p;
      mag = (u < 0) ? 64'(-longint'(u)) : 64'(u);
      p = (mag * 64'(dev)) >> 15;
      return p * p;
    endfunction

    function logic [63:0] fused_dev(logic signed [cjv_pkg::DIR_W-1:0] ux,
                                    logic signed [cjv_pkg::DIR_W-1:0] uy,
                                    logic signed [cjv_pkg::DIR_W-1:0] uz);
      return root(axis_sq(ux, dev_x) + axis_sq(uy, dev_y) + axis_sq(uz, dev_z));
    endfunction

    function void note_word(logic signed [cjv_pkg::DIR_W-1:0] px,
                            logic signed [cjv_pkg::DIR_W-1:0] py,
                            logic signed [cjv_pkg::DIR_W-1:0] pz,
                            logic signed [cjv_pkg::DIR_W-1:0] nx,
                            logic signed [cjv_pkg::DIR_W-1:0] ny,
                            logic signed [cjv_pkg::DIR_W-1:0] nz);
      longint      cosv;
      logic [63:0] delta, x, s, den, radius, acc, spd;
      corner_t     c;
      cosv = -(longint'(px) * nx + longint'(py) * ny + longint'(pz) * nz);
      if (cosv < -longint'(cjv_pkg::COS_LIMIT)) begin
        c.speed = cjv_pkg::STRAIGHT;
        c.kind  = cjv_pkg::KIND_STRAIGHT;
      end else if (cosv > longint'(cjv_pkg::COS_LIMIT)) begin
        c.speed = '0;
        c.kind  = cjv_pkg::KIND_REVERSAL;
      end else begin
        delta = (fused_dev(px, py, pz) + fused_dev(nx, ny, nz)) >> 1;
        x = 64'(longint'(Q30_ONE) - cosv) >> 1;
        s = root(x << 30);
        den = (s < Q30_ONE) ? Q30_ONE - s : 64'd1;
        radius = (delta * s) / den;
        acc = 64'(accel);
        if (acc != 0 && radius > CORNER_SQ / acc) begin
          spd = 64'(cjv_pkg::STRAIGHT);
        end else begin
          spd = root(radius * acc);
          if (spd > 64'(cjv_pkg::STRAIGHT)) spd = 64'(cjv_pkg::STRAIGHT);
        end
        c.speed = spd[cjv_pkg::SPEED_W-1:0];
        c.kind  = cjv_pkg::KIND_COMPUTED;
      end
      pending.push_back(c);
    endfunction

    function void report(string msg);
      $display("ERROR: %s", msg);
      mismatches++;
    endfunction

    function void check_result(logic [cjv_pkg::SPEED_W-1:0] speed,
                               logic [cjv_pkg::KIND_W-1:0] kind);
      corner_t c;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word speed=%0d kind=%0d", speed, kind));
        return;
      end
      c = pending.pop_front();
      if (speed !== c.speed)
        report($sformatf("speed got %0d want %0d", speed, c.speed));
      if (kind !== c.kind)
        report($sformatf("kind got %0d want %0d", kind, c.kind));
    endfunction
  endclass

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic signed [cjv_pkg::DIR_W-1:0]   prev_dir_x_i = '0, prev_dir_y_i = '0, prev_dir_z_i = '0;
  logic signed [cjv_pkg::DIR_W-1:0]   next_dir_x_i = '0, next_dir_y_i = '0, next_dir_z_i = '0;
  logic                               result_valid_o;
  logic [cjv_pkg::SPEED_W-1:0]        corner_speed_o;
  logic [cjv_pkg::KIND_W-1:0]         corner_kind_o;
  logic                               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [cjv_pkg::ADDR_W-1:0]         paddr = '0;
  logic [cjv_pkg::DATA_W-1:0]         pwdata = '0;
  logic [cjv_pkg::DATA_W-1:0]         prdata;
  logic                               pready;

  corner_scoreboard sb = new();
  int               cycles = 0;
  int               idle_pct = 0;

  always #5 clk_i = ~clk_i;

  corner_junction_velocity_limit_unit i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .prev_dir_x_i, .prev_dir_y_i, .prev_dir_z_i,
    .next_dir_x_i, .next_dir_y_i, .next_dir_z_i,
    .result_valid_o, .corner_speed_o, .corner_kind_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Monitor: values seen here are the ones before this edge's updates
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && start && !busy)
      sb.note_word(prev_dir_x_i, prev_dir_y_i, prev_dir_z_i,
                   next_dir_x_i, next_dir_y_i, next_dir_z_i);
    if (rst_ni && result_valid_o)
      sb.check_result(corner_speed_o, corner_kind_o);
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Push one word, with random sender gaps in front of it
  task automatic send_word(logic signed [cjv_pkg::DIR_W-1:0] px,
                           logic signed [cjv_pkg::DIR_W-1:0] py,
                           logic signed [cjv_pkg::DIR_W-1:0] pz,
                           logic signed [cjv_pkg::DIR_W-1:0] nx,
                           logic signed [cjv_pkg::DIR_W-1:0] ny,
                           logic signed [cjv_pkg::DIR_W-1:0] nz);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    prev_dir_x_i <= px; prev_dir_y_i <= py; prev_dir_z_i <= pz;
    next_dir_x_i <= nx; next_dir_y_i <= ny; next_dir_z_i <= nz;
    do @(posedge clk_i); while (busy);
  endtask

  // Wait out every outstanding word, then the pipeline tail
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(cjv_pkg::reg_e idx, logic [cjv_pkg::DATA_W-1:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= cjv_pkg::ADDR_W'(4 * int'(idx)); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [cjv_pkg::DEV_W-1:0] dx, logic [cjv_pkg::DEV_W-1:0] dy,
                          logic [cjv_pkg::DEV_W-1:0] dz, logic [cjv_pkg::ACC_W-1:0] acc);
    write_reg(cjv_pkg::REG_DEV_X, cjv_pkg::DATA_W'(dx));
    write_reg(cjv_pkg::REG_DEV_Y, cjv_pkg::DATA_W'(dy));
    write_reg(cjv_pkg::REG_DEV_Z, cjv_pkg::DATA_W'(dz));
    write_reg(cjv_pkg::REG_ACCEL, acc);
  endtask

  // Directed junctions: straight, reversal, right angle, extremes, zero vectors
  task automatic directed_words();
    send_word(32767, 0, 0, 32767, 0, 0);
    send_word(0, 32767, 0, 0, -32767, 0);
    send_word(32767, 0, 0, 0, 32767, 0);
    send_word(0, 0, 32767, 0, 0, 32767);
    send_word(-32768, -32768, -32768, -32768, -32768, -32768);
    send_word(-32768, -32768, -32768, 32767, 32767, 32767);
    send_word(32767, 32767, 32767, 32767, 32767, 32767);
    send_word(0, 0, 0, 0, 0, 0);
    send_word(0, 0, 0, 32767, -32768, 32767);
    send_word(23170, 23170, 0, 32767, 0, 0);
    send_word(23170, 23170, 0, -32767, 0, 0);
    send_word(32767, 0, 0, 32440, 4600, 0);
    send_word(32767, 0, 0, -32440, 4600, 0);
    send_word(18918, 18918, 18918, -18918, 18918, -18918);
    send_word(-32768, 0, 0, 0, 0, -32768);
    send_word(-1, -1, -1, 1, 1, 1);
    send_word(16384, -16384, 16384, 16384, 16384, -16384);
    send_word(32767, 32767, -32768, -32768, 0, 32767);
  endtask

  function automatic logic signed [cjv_pkg::DIR_W-1:0] nudge(
      logic signed [cjv_pkg::DIR_W-1:0] v, int amt);
    int t;
    t = int'(v) + int'($urandom_range(2 * amt)) - amt;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return cjv_pkg::DIR_W'(t);
  endfunction

  // Mostly near-unit junctions, many close to the thresholds, some raw noise
  task automatic random_words(int n);
    logic signed [cjv_pkg::DIR_W-1:0] a[3], b[3];
    int sel, amt, sgn;
    repeat (n) begin
      sel = $urandom_range(9);
      a[0] = cjv_pkg::DIR_W'($urandom);
      a[1] = cjv_pkg::DIR_W'($urandom);
      a[2] = cjv_pkg::DIR_W'($urandom);
      if (sel < 2) begin
        b[0] = cjv_pkg::DIR_W'($urandom);
        b[1] = cjv_pkg::DIR_W'($urandom);
        b[2] = cjv_pkg::DIR_W'($urandom);
      end else begin
        // Pick a dominant axis so the vector is near unit length
        a[0] = $urandom_range(1) ? cjv_pkg::DIR_W'(32767) : cjv_pkg::DIR_W'(-32768);
        a[1] = cjv_pkg::DIR_W'(int'($urandom_range(4000)) - 2000);
        a[2] = cjv_pkg::DIR_W'(int'($urandom_range(4000)) - 2000);
        if ($urandom_range(1)) begin
          a = '{a[1], a[0], a[2]};
        end
        amt = (sel < 6) ? 1200 : 20000;
        sgn = $urandom_range(1);
        b[0] = nudge(sgn ? a[0] : -a[0], amt);
        b[1] = nudge(sgn ? a[1] : -a[1], amt);
        b[2] = nudge(sgn ? a[2] : -a[2], amt);
      end
      send_word(a[0], a[1], a[2], b[0], b[1], b[2]);
    end
  endtask

  initial begin
    sb.reset_regs();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults, full rate
    idle_pct = 0;
    directed_words();
    random_words(RANDOM_N / 5);
    drain();

    // Largest deviations and acceleration: saturation path
    set_regs('1, '1, '1, '1);
    directed_words();
    idle_pct = 86;
    random_words(RANDOM_N / 5);
    drain();

    // Zero deviations and zero acceleration
    set_regs('0, '0, '0, '0);
    idle_pct = 6;
    directed_words();
    random_words(RANDOM_N / 10);
    drain();

    // Random settings, mixed gaps
    repeat (3) begin
      set_regs(cjv_pkg::DEV_W'($urandom_range(200000)), cjv_pkg::DEV_W'($urandom),
               cjv_pkg::DEV_W'($urandom_range(70000)), cjv_pkg::ACC_W'($urandom));
      idle_pct = $urandom_range(2) == 0 ? 0 : 40;
      random_words(RANDOM_N / 6);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (sb.pending.size() != 0)
        $display("ERROR: %0d words never came back", sb.pending.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
